[hw/rtl/mtm_pkg.sv]
// Shared types and constants of the MIDI trigger mapper.
// Used by the channel interfaces, the map cells, the cell chain and the top level.
package mtm_pkg;

    // Default number of program map entries.
    localparam int DEF_MAP_ENTRIES = 128;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_KIND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_START_VALUE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_KIND  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PAUSE_VALUE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_KIND   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_STOP_VALUE  = 3'd6;

    // Item operations.
    localparam logic OP_BYTE = 1'b0;
    localparam logic OP_MAP  = 1'b1;

    // Realtime bytes.
    localparam logic [7:0] RT_START = 8'hFA;
    localparam logic [7:0] RT_CONT  = 8'hFB;
    localparam logic [7:0] RT_STOP  = 8'hFC;

    // Status byte upper nibbles.
    localparam logic [3:0] STAT_NOTE = 4'h9;
    localparam logic [3:0] STAT_CC   = 4'hB;
    localparam logic [3:0] STAT_PC   = 4'hC;

    // Trigger kinds.
    localparam logic [1:0] TRIG_CC   = 2'd0;
    localparam logic [1:0] TRIG_NOTE = 2'd1;
    localparam logic [1:0] TRIG_PC   = 2'd2;
    localparam logic [1:0] TRIG_OFF  = 2'd3;

    // Program map entry kinds.
    localparam logic [1:0] MAP_PC     = 2'd0;
    localparam logic [1:0] MAP_CC     = 2'd1;
    localparam logic [1:0] MAP_NOTE   = 2'd2;
    localparam logic [1:0] MAP_UNUSED = 2'd3;

    typedef struct packed {
        logic       operation;
        logic [7:0] midi_byte;
        logic       player_free;
        logic [6:0] map_index;
        logic [1:0] map_kind;
        logic [7:0] map_value;
    } mtm_in_t;

    typedef struct packed {
        logic       do_start;
        logic       do_pause;
        logic       do_stop;
        logic       program_valid;
        logic [6:0] program_number;
        logic       thru_valid;
        logic [7:0] thru_byte;
    } mtm_out_t;

    // Search token that walks down the cell chain.
    typedef struct packed {
        logic       active;
        logic [1:0] kind;
        logic [7:0] value;
        logic       found;
        logic [6:0] num;
    } mtm_token_t;

    // Map entry write, broadcast to every cell.
    typedef struct packed {
        logic       en;
        logic [6:0] index;
        logic [1:0] kind;
        logic [7:0] value;
    } mtm_wr_t;

endpackage

[hw/rtl/mtm_if.sv]
// Valid/ready channel interfaces of the MIDI trigger mapper.
// Depends on mtm_pkg for the item payload types.
interface mtm_midi_if;
    import mtm_pkg::*;

    logic    valid;
    logic    ready;
    mtm_in_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface mtm_result_if;
    import mtm_pkg::*;

    logic     valid;
    logic     ready;
    mtm_out_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/mtm_cell.sv]
// One program map cell: holds one map entry and one stage of the search token.
// Depends on mtm_pkg.
module mtm_cell #(
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtm_pkg::mtm_wr_t    wr,
    input  mtm_pkg::mtm_token_t tok_in,
    output mtm_pkg::mtm_token_t tok_out
);
    import mtm_pkg::*;

    localparam logic [7:0] CELL_ID  = 8'(INDEX);
    localparam logic [6:0] CELL_NUM = 7'(INDEX);

    logic [1:0] kind_reg;
    logic [7:0] value_reg;
    logic       act_reg;
    mtm_token_t tok_reg;
    mtm_token_t tok_next;
    logic       hit;

    // Entry storage, written by address decode of the broadcast write.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg  <= MAP_UNUSED;
            value_reg <= 8'd0;
        end
        else if (wr.en && ({1'b0, wr.index} == CELL_ID))
        begin
            kind_reg  <= wr.kind;
            value_reg <= wr.value;
        end
    end

    // The first cell that matches claims the token; later cells pass it on.
    assign hit = tok_in.active && !tok_in.found &&
                 (kind_reg == tok_in.kind) && (value_reg == tok_in.value);

    always_comb
    begin
        tok_next       = tok_in;
        tok_next.found = tok_in.found | hit;
        tok_next.num   = hit ? CELL_NUM : tok_in.num;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= tok_in.active;
        end
    end

    always_ff @(posedge clk)
    begin
        tok_reg <= tok_next;
    end

    always_comb
    begin
        tok_out        = tok_reg;
        tok_out.active = act_reg;
    end

endmodule

[hw/rtl/mtm_chain.sv]
// Row of program map cells; the search token advances one cell per cycle.
// Depends on mtm_pkg and mtm_cell.
module mtm_chain #(
    parameter int MAP_ENTRIES = mtm_pkg::DEF_MAP_ENTRIES
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mtm_pkg::mtm_wr_t    wr,
    input  mtm_pkg::mtm_token_t tok_in,
    output mtm_pkg::mtm_token_t tok_out
);
    import mtm_pkg::*;

    mtm_token_t link [MAP_ENTRIES+1];

    assign link[0] = tok_in;

    for (genvar g = 0; g < MAP_ENTRIES; g++)
    begin : g_cell
        mtm_cell #(
            .INDEX (g)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .wr      (wr),
            .tok_in  (link[g]),
            .tok_out (link[g+1])
        );
    end

    assign tok_out = link[MAP_ENTRIES];

endmodule

[hw/rtl/midi_trigger_mapper.sv]
// Top level of the MIDI trigger mapper: parser, sequencer, output register.
// Depends on mtm_pkg, mtm_if and mtm_chain.
//
// Usage: items arrive on the midi channel (valid/ready). An item is either a
// received MIDI byte or a write of one program map entry. Each item yields
// exactly one item on the result channel: the echoed byte, the start, pause
// and stop pulses, and the selected program if a map entry matched. A map
// write yields an item with every field zero.
// The block works on one item at a time. A data byte that needs a program map
// lookup sends a search token down the row of MAP_ENTRIES cells, one cell per
// cycle; its program fields enter the pending result when the token leaves
// the last cell, and the length of the cell chain sets how long that takes.
// Any pending result then moves into the output register, and only after that
// is the next item taken. A finished result sits in an output register, so
// the next input item is accepted while the receiver stalls; the sequencer
// only waits when a second result is ready and the register is still full.
// Reset clears the parser to idle, every map entry to kind unused, and the
// configuration registers to their defaults (channel 0, all triggers off).
// The user writes configuration through cfg_we/cfg_index/cfg_data only while
// idle; the block itself does not enforce this.
module midi_trigger_mapper #(
    parameter int MAP_ENTRIES = mtm_pkg::DEF_MAP_ENTRIES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    mtm_midi_if.sink                         midi,
    mtm_result_if.source                     result,
    input  logic                             cfg_we,
    input  logic [mtm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [mtm_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import mtm_pkg::*;

    // Parser state of the MIDI byte stream.
    typedef enum logic [4:0] {
        P_IDLE = 5'b00001,
        P_CC   = 5'b00010,
        P_NOTE = 5'b00100,
        P_PC   = 5'b01000,
        P_SKIP = 5'b10000
    } parser_t;

    // Item sequencer: take an item, wait for the map search, deliver.
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } seq_t;

    // Configuration registers.
    logic [3:0] channel_reg;
    logic [1:0] start_kind_reg;
    logic [7:0] start_value_reg;
    logic [1:0] pause_kind_reg;
    logic [7:0] pause_value_reg;
    logic [1:0] stop_kind_reg;
    logic [7:0] stop_value_reg;

    parser_t    parser_reg;
    parser_t    parser_next;
    seq_t       seq_reg;
    seq_t       seq_next;

    mtm_out_t   pend_reg;
    mtm_out_t   pend_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    mtm_out_t   out_data_reg;
    mtm_out_t   out_data_next;

    logic       accept;
    logic       accept_byte;
    logic       launch;
    logic       armed;
    logic [1:0] trig_kind;
    logic [1:0] map_kind;
    logic [7:0] rx;
    logic       hit_start;
    logic       hit_pause;
    logic       hit_stop;
    logic       out_free;

    mtm_wr_t    map_wr;
    mtm_token_t tok_in;
    mtm_token_t tok_out;

    //--------------------------------------------------------------------
    // Configuration port. Indexes beyond the register list are ignored.
    //--------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            channel_reg     <= 4'd0;
            start_kind_reg  <= TRIG_OFF;
            start_value_reg <= 8'd0;
            pause_kind_reg  <= TRIG_OFF;
            pause_value_reg <= 8'd0;
            stop_kind_reg   <= TRIG_OFF;
            stop_value_reg  <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_CHANNEL:     channel_reg     <= cfg_data[3:0];
                REG_START_KIND:  start_kind_reg  <= cfg_data[1:0];
                REG_START_VALUE: start_value_reg <= cfg_data;
                REG_PAUSE_KIND:  pause_kind_reg  <= cfg_data[1:0];
                REG_PAUSE_VALUE: pause_value_reg <= cfg_data;
                REG_STOP_KIND:   stop_kind_reg   <= cfg_data[1:0];
                REG_STOP_VALUE:  stop_value_reg  <= cfg_data;
                default:         ;
            endcase
        end
    end

    //--------------------------------------------------------------------
    // Input handshake. Items are taken only when the sequencer is free.
    //--------------------------------------------------------------------
    assign midi.ready  = (seq_reg == S_IDLE);
    assign accept      = midi.valid && midi.ready;
    assign accept_byte = accept && (midi.data.operation == OP_BYTE);
    assign rx          = midi.data.midi_byte;

    //--------------------------------------------------------------------
    // Parser. In idle, realtime bytes raise actions and status bytes on
    // our channel arm the parser. When armed, the byte is data: it is
    // compared with the triggers and, with the player idle, searched for
    // in the program map. A CC or note data byte is followed by one
    // skipped byte; a program change returns straight to idle.
    //--------------------------------------------------------------------
    always_comb
    begin
        parser_next = parser_reg;
        armed       = 1'b0;
        trig_kind   = TRIG_CC;
        map_kind    = MAP_CC;
        hit_start   = 1'b0;
        hit_pause   = 1'b0;
        hit_stop    = 1'b0;

        case (parser_reg)
            P_IDLE:
            begin
                hit_start = (rx == RT_START);
                hit_pause = (rx == RT_CONT);
                hit_stop  = (rx == RT_STOP);
                if (rx == {STAT_CC, channel_reg})
                begin
                    parser_next = P_CC;
                end
                else if (rx == {STAT_NOTE, channel_reg})
                begin
                    parser_next = P_NOTE;
                end
                else if (rx == {STAT_PC, channel_reg})
                begin
                    parser_next = P_PC;
                end
            end
            P_CC:
            begin
                armed       = 1'b1;
                trig_kind   = TRIG_CC;
                map_kind    = MAP_CC;
                parser_next = P_SKIP;
            end
            P_NOTE:
            begin
                armed       = 1'b1;
                trig_kind   = TRIG_NOTE;
                map_kind    = MAP_NOTE;
                parser_next = P_SKIP;
            end
            P_PC:
            begin
                armed       = 1'b1;
                trig_kind   = TRIG_PC;
                map_kind    = MAP_PC;
                parser_next = P_IDLE;
            end
            default:
            begin
                parser_next = P_IDLE;
            end
        endcase

        if (armed)
        begin
            hit_start = (start_kind_reg == trig_kind) && (start_value_reg == rx);
            hit_pause = (pause_kind_reg == trig_kind) && (pause_value_reg == rx);
            hit_stop  = (stop_kind_reg == trig_kind) && (stop_value_reg == rx);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parser_reg <= P_IDLE;
        end
        else if (accept_byte)
        begin
            parser_reg <= parser_next;
        end
    end

    //--------------------------------------------------------------------
    // Program map: a row of cells. Map writes are broadcast; an index
    // without a cell is simply not picked up by any cell.
    //--------------------------------------------------------------------
    assign launch = accept_byte && armed && midi.data.player_free;

    always_comb
    begin
        map_wr.en    = accept && (midi.data.operation == OP_MAP);
        map_wr.index = midi.data.map_index;
        map_wr.kind  = midi.data.map_kind;
        map_wr.value = midi.data.map_value;

        tok_in.active = launch;
        tok_in.kind   = map_kind;
        tok_in.value  = rx;
        tok_in.found  = 1'b0;
        tok_in.num    = 7'd0;
    end

    mtm_chain #(
        .MAP_ENTRIES (MAP_ENTRIES)
    ) u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (map_wr),
        .tok_in  (tok_in),
        .tok_out (tok_out)
    );

    //--------------------------------------------------------------------
    // Sequencer and pending result. The pending result is built at
    // acceptance; the program fields are filled in when the token leaves
    // the last cell. It then moves into the output register as soon as
    // that register is empty or being emptied.
    //--------------------------------------------------------------------
    assign out_free = !out_valid_reg || result.ready;

    always_comb
    begin
        seq_next       = seq_reg;
        pend_next      = pend_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (seq_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    pend_next = '0;
                    if (midi.data.operation == OP_BYTE)
                    begin
                        pend_next.do_start   = hit_start;
                        pend_next.do_pause   = hit_pause;
                        pend_next.do_stop    = hit_stop;
                        pend_next.thru_valid = 1'b1;
                        pend_next.thru_byte  = rx;
                    end
                    seq_next = launch ? S_SCAN : S_DONE;
                end
            end
            S_SCAN:
            begin
                if (tok_out.active)
                begin
                    pend_next.program_valid  = tok_out.found;
                    pend_next.program_number = tok_out.found ? tok_out.num : 7'd0;
                    seq_next                 = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = pend_reg;
                    seq_next       = S_IDLE;
                end
            end
            default:
            begin
                seq_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg       <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            seq_reg       <= seq_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_data_reg <= out_data_next;
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    //--------------------------------------------------------------------
    // Assertions.
    //--------------------------------------------------------------------

    // A search token can only leave the chain while the sequencer waits for it.
    a_token_in_scan: assert property (
        @(posedge clk) disable iff (!rst_n)
        tok_out.active |-> (seq_reg == S_SCAN)
    ) else $error("search token left the cell chain outside a scan");

    // A map write never starts a search and goes straight to delivery.
    a_map_write_done: assert property (
        @(posedge clk) disable iff (!rst_n)
        (accept && (midi.data.operation == OP_MAP)) |=> (seq_reg == S_DONE)
    ) else $error("map write did not go straight to delivery");

    // A selected program is only ever reported with an echoed MIDI byte.
    a_program_with_thru: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_data_reg.program_valid) |-> out_data_reg.thru_valid
    ) else $error("program selection reported without a MIDI byte");

endmodule
